### rtl/core/srfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial reply frame receiver package
// Shared constants, command codes, register indexes and frame/result types.
// ----------------------------------------------------------------------------
package srfr_pkg;

	localparam int FRAME_BYTES = 10;
	localparam int POS_W       = 4;
	localparam int STORE_DEPTH = FRAME_BYTES - 2;
	localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

	localparam logic [POS_W-1:0] POS_IDLE = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	localparam int CFG_DATA_W = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int OUT_DATA_W = 136;

	localparam logic [CFG_ADDR_W-1:0] REG_UNKNOWN_STATUS = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_STOPPED_STATUS = CFG_ADDR_W'(1);
	localparam logic [CFG_ADDR_W-1:0] REG_NO_ERROR       = CFG_ADDR_W'(2);

	localparam logic [15:0] UNKNOWN_STATUS_RESET = 16'd255;
	localparam logic [15:0] STOPPED_STATUS_RESET = 16'd0;
	localparam logic [15:0] NO_ERROR_RESET       = 16'd0;

	localparam logic [7:0] START_BYTE   = 8'h7E;
	localparam logic [7:0] END_BYTE     = 8'hEF;
	localparam logic [7:0] VERSION_BYTE = 8'hFF;
	localparam logic [7:0] LENGTH_BYTE  = 8'h06;

	localparam logic [7:0] CMD_INIT       = 8'h3F;
	localparam logic [7:0] CMD_INSERT     = 8'h3A;
	localparam logic [7:0] CMD_REMOVE     = 8'h3B;
	localparam logic [7:0] CMD_FINISH_USB = 8'h3C;
	localparam logic [7:0] CMD_FINISH_TF  = 8'h3D;
	localparam logic [7:0] CMD_FINISH_FL  = 8'h3E;
	localparam logic [7:0] CMD_ERROR      = 8'h40;
	localparam logic [7:0] CMD_ACK        = 8'h41;
	localparam logic [7:0] CMD_STATUS     = 8'h42;
	localparam logic [7:0] CMD_VOLUME     = 8'h43;
	localparam logic [7:0] CMD_EQ         = 8'h44;

	typedef struct packed {
		logic [7:0] version;
		logic [7:0] length;
		logic [7:0] command;
		logic [7:0] feedback;
		logic [7:0] param_hi;
		logic [7:0] param_lo;
		logic [7:0] sum_hi;
		logic [7:0] sum_lo;
		logic [7:0] end_byte;
	} frame_t;

	// First member lands in the highest bits, so last_command ends up at bit 0.
	typedef struct packed {
		logic [15:0] query_result;
		logic [7:0]  eq_mode;
		logic [7:0]  volume_level;
		logic [7:0]  finished_source;
		logic [15:0] finished_track;
		logic [15:0] error_code;
		logic [15:0] play_status;
		logic [15:0] device_mask;
		logic        player_online;
		logic [15:0] last_parameter;
		logic [7:0]  last_command;
	} status_t;

endpackage
`default_nettype wire

### rtl/core/srfr_collect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame collector
// Tracks the byte position, stores the frame bytes and flags a complete frame.
// ----------------------------------------------------------------------------
module srfr_collect (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [7:0]     s_tdata,
	input  wire logic           out_stall,
	output logic                frame_done,
	output srfr_pkg::frame_t    frame
);
	import srfr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       store_q [STORE_DEPTH];
	logic             in_fire;
	logic             is_start;
	logic [STORE_IDX_W-1:0] wr_idx;

	// The closing byte needs the result register, so only that byte waits on it.
	assign s_tready   = (pos_q != POS_LAST) || !out_stall;
	assign in_fire    = s_tvalid && s_tready;
	assign is_start   = (s_tdata == START_BYTE);
	assign wr_idx     = STORE_IDX_W'(pos_q - POS_W'(1));
	assign frame_done = in_fire && !is_start && (pos_q == POS_LAST);

	assign frame.version  = store_q[0];
	assign frame.length   = store_q[1];
	assign frame.command  = store_q[2];
	assign frame.feedback = store_q[3];
	assign frame.param_hi = store_q[4];
	assign frame.param_lo = store_q[5];
	assign frame.sum_hi   = store_q[6];
	assign frame.sum_lo   = store_q[7];
	assign frame.end_byte = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
		end else if (in_fire) begin
			if (is_start) begin
				pos_q <= POS_W'(1);
			end else if (pos_q == POS_IDLE || pos_q == POS_LAST) begin
				pos_q <= POS_IDLE;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !is_start && pos_q != POS_IDLE && pos_q != POS_LAST) begin
			store_q[wr_idx] <= s_tdata;
		end
	end

endmodule
`default_nettype wire

### rtl/core/srfr_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame check and status update
// Validates a complete frame, updates the status registers and holds the result.
// ----------------------------------------------------------------------------
module srfr_update (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [srfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [srfr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                               frame_done,
	input  wire srfr_pkg::frame_t                   frame,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output srfr_pkg::status_t                       result,
	output logic                                    result_ok
);
	import srfr_pkg::*;

	localparam status_t STATE_RESET = '{
		query_result:    16'd0,
		eq_mode:         8'd0,
		volume_level:    8'd0,
		finished_source: 8'd0,
		finished_track:  16'd0,
		error_code:      NO_ERROR_RESET,
		play_status:     UNKNOWN_STATUS_RESET,
		device_mask:     16'd0,
		player_online:   1'b0,
		last_parameter:  16'd0,
		last_command:    8'd0
	};

	logic [15:0] stopped_code_q;
	logic [15:0] no_error_code_q;
	status_t     state_q;
	status_t     state_next;
	status_t     result_q;
	logic        ok_q;
	logic        valid_q;
	logic [15:0] sum;
	logic [15:0] par;
	logic        good;

	assign par = {frame.param_hi, frame.param_lo};
	assign sum = 16'({8'h00, VERSION_BYTE}) + 16'({8'h00, LENGTH_BYTE})
		+ 16'({8'h00, frame.command}) + 16'({8'h00, frame.feedback})
		+ 16'({8'h00, frame.param_hi}) + 16'({8'h00, frame.param_lo});
	assign good = (frame.version == VERSION_BYTE) && (frame.length == LENGTH_BYTE)
		&& (frame.end_byte == END_BYTE) && ((16'd0 - sum) == {frame.sum_hi, frame.sum_lo});

	always_comb begin
		state_next = state_q;
		if (good) begin
			state_next.last_command   = frame.command;
			state_next.last_parameter = par;
			unique case (frame.command)
				CMD_INIT: begin
					state_next.player_online = 1'b1;
					state_next.device_mask   = par;
					state_next.error_code    = no_error_code_q;
				end
				CMD_INSERT: begin
					state_next.device_mask   = state_q.device_mask | par;
					state_next.player_online = 1'b1;
				end
				CMD_REMOVE: begin
					state_next.device_mask = state_q.device_mask & ~par;
				end
				CMD_FINISH_USB, CMD_FINISH_TF, CMD_FINISH_FL: begin
					state_next.finished_source = frame.command;
					state_next.finished_track  = par;
					state_next.play_status     = stopped_code_q;
				end
				CMD_ERROR: begin
					state_next.error_code = par;
				end
				CMD_ACK: begin
					state_next.error_code = no_error_code_q;
				end
				CMD_STATUS: begin
					state_next.play_status  = par;
					state_next.query_result = par;
				end
				CMD_VOLUME: begin
					state_next.volume_level = frame.param_lo;
					state_next.query_result = par;
				end
				CMD_EQ: begin
					state_next.eq_mode      = frame.param_lo;
					state_next.query_result = par;
				end
				default: begin
					state_next.query_result = par;
				end
			endcase
		end
	end

	// The unknown status code is only the reset value of the play status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_code_q  <= STOPPED_STATUS_RESET;
			no_error_code_q <= NO_ERROR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_UNKNOWN_STATUS: begin
				end
				REG_STOPPED_STATUS: begin
					stopped_code_q <= cfg_wdata;
				end
				REG_NO_ERROR: begin
					no_error_code_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			valid_q <= 1'b0;
		end else begin
			if (frame_done) begin
				state_q <= state_next;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			result_q <= state_next;
			ok_q     <= good;
		end
	end

	assign m_tvalid  = valid_q;
	assign result    = result_q;
	assign result_ok = ok_q;

endmodule
`default_nettype wire

### rtl/core/serial_reply_frame_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial reply frame receiver
// Parses ten-byte reply frames from a byte stream and reports module status.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle. A start byte 0x7E always
// opens a new frame, and bytes outside a frame are dropped. The tenth byte of
// a frame completes it: the header, end byte and checksum are checked in that
// same cycle and the result transfer is offered on the output in the next cycle,
// with tuser high for a good frame. Every byte except the tenth is taken even
// while a result is still waiting; the tenth waits only until the single
// output register is free, so with the output side ready the block sustains
// one byte per cycle without pause.
module serial_reply_frame_receiver_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [srfr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [srfr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [7:0]                         s_tdata,   // rx_byte
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// last_command, last_parameter, player_online, device_mask, play_status,
	// error_code, finished_track, finished_source, volume_level, eq_mode,
	// query_result, zero padding
	output logic [srfr_pkg::OUT_DATA_W-1:0]         m_tdata,
	output logic                                    m_tuser    // frame_ok
);
	import srfr_pkg::*;

	logic    frame_done;
	frame_t  frame;
	status_t result;
	logic    result_ok;

	srfr_collect u_collect (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.out_stall  (m_tvalid && !m_tready),
		.frame_done (frame_done),
		.frame      (frame)
	);

	srfr_update u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.frame_done (frame_done),
		.frame      (frame),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.result     (result),
		.result_ok  (result_ok)
	);

	assign m_tdata = {(OUT_DATA_W - $bits(status_t))'(0), result};
	assign m_tuser = result_ok;

endmodule
`default_nettype wire
